@@ sv/bmc_pkg.sv @@
// Shared types and constants for the box matching cost block.
// Used by bmc_front, bmc_fifo, bmc_back and box_match_cost_top; no dependencies.
package bmc_pkg;

  localparam int CoordMaxDefault = 4095;
  localparam int FieldW = 12;          // width of every input field
  localparam int SpanW  = FieldW + 1;  // edges, spans, centers, offsets
  localparam int AreaW  = 2 * SpanW - 1; // products of two spans, below 2^25
  localparam int UniW   = AreaW + 1;
  localparam int DxyW   = 2 * SpanW;
  localparam int AwhW   = 2 * FieldW;
  localparam int Num1W  = DxyW + 7;    // dx*dy*100
  localparam int NumW   = Num1W + UniW;
  localparam int DenW   = UniW + AwhW;
  localparam int QW     = 31;
  localparam int ShW    = DenW + QW;   // divisor shifted by the full quotient width
  localparam int FifoDepth = 4;

  localparam logic [QW-1:0] CostMax = '1;
  localparam logic [QW-1:0] CostOne = QW'(1);

  // Geometry of one box pair, produced by the front end
  typedef struct packed {
    logic [SpanW-1:0]  wx;   // intersection width, 0 when empty
    logic [SpanW-1:0]  hx;   // intersection height, 0 when empty
    logic [SpanW-1:0]  aw1;
    logic [SpanW-1:0]  ah1;
    logic [SpanW-1:0]  bw1;
    logic [SpanW-1:0]  bh1;
    logic [SpanW-1:0]  dx;
    logic [SpanW-1:0]  dy;
    logic [FieldW-1:0] aw;
    logic [FieldW-1:0] ah;
  } bmc_geom_t;

endpackage

@@ sv/bmc_front.sv @@
// Front end: takes a box pair, clamps coordinates and works out spans and offsets.
// Depends on bmc_pkg.
module bmc_front #(
  parameter int COORD_MAX = bmc_pkg::CoordMaxDefault
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic [8*bmc_pkg::FieldW-1:0] in_data_i,
  output logic                      geom_valid_o,
  input  logic                      geom_ready_i,
  output bmc_pkg::bmc_geom_t        geom_o
);
  import bmc_pkg::*;

  localparam logic [15:0] CmaxW = 16'(COORD_MAX);
  localparam logic [FieldW-1:0] Clamp =
    (CmaxW > 16'((1 << FieldW) - 1)) ? '1 : CmaxW[FieldW-1:0];

  logic [FieldW-1:0] f [8];
  logic [SpanW-1:0]  ar, br, at, bt, xb, yb, xa, ya, cxa, cxb, cya, cyb;
  logic              ne;
  bmc_geom_t         geom_d, geom_q;
  logic              valid_q;

  // clamp every field to the coordinate limit
  always_comb begin
    for (int k = 0; k < 8; k++) begin
      f[k] = in_data_i[k*FieldW +: FieldW];
      if (f[k] > Clamp) f[k] = Clamp;
    end
  end

  // intersection spans, box sizes and center offsets
  always_comb begin
    ar  = SpanW'(f[0]) + SpanW'(f[2]);
    at  = SpanW'(f[1]) + SpanW'(f[3]);
    br  = SpanW'(f[4]) + SpanW'(f[6]);
    bt  = SpanW'(f[5]) + SpanW'(f[7]);
    xa  = SpanW'((f[0] > f[4]) ? f[0] : f[4]);
    ya  = SpanW'((f[1] > f[5]) ? f[1] : f[5]);
    xb  = (ar < br) ? ar : br;
    yb  = (at < bt) ? at : bt;
    ne  = (xb > xa) && (yb > ya);
    cxa = SpanW'(f[0]) + SpanW'(f[2] >> 1);
    cxb = SpanW'(f[4]) + SpanW'(f[6] >> 1);
    cya = SpanW'(f[1]) + SpanW'(f[3] >> 1);
    cyb = SpanW'(f[5]) + SpanW'(f[7] >> 1);
    geom_d.wx  = ne ? (xb - xa + SpanW'(1)) : '0;
    geom_d.hx  = ne ? (yb - ya + SpanW'(1)) : '0;
    geom_d.aw1 = SpanW'(f[2]) + SpanW'(1);
    geom_d.ah1 = SpanW'(f[3]) + SpanW'(1);
    geom_d.bw1 = SpanW'(f[6]) + SpanW'(1);
    geom_d.bh1 = SpanW'(f[7]) + SpanW'(1);
    geom_d.dx  = (cxa > cxb) ? (cxa - cxb) : (cxb - cxa);
    geom_d.dy  = (cya > cyb) ? (cya - cyb) : (cyb - cya);
    geom_d.aw  = f[2];
    geom_d.ah  = f[3];
  end

  assign in_ready_o = !valid_q || geom_ready_i;

  // single register stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      geom_q <= geom_d;
    end
  end

  assign geom_valid_o = valid_q;
  assign geom_o       = geom_q;

endmodule

@@ sv/bmc_fifo.sv @@
// Short queue of box pair geometry between front and back ends.
// Depends on bmc_pkg.
module bmc_fifo (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               wr_valid_i,
  output logic               wr_ready_o,
  input  bmc_pkg::bmc_geom_t wr_data_i,
  output logic               rd_valid_o,
  input  logic               rd_ready_i,
  output bmc_pkg::bmc_geom_t rd_data_o
);
  import bmc_pkg::*;

  localparam int PtrW = $clog2(FifoDepth);

  bmc_geom_t       mem_q [FifoDepth];
  logic [PtrW-1:0] wp_q, rp_q;
  logic [PtrW:0]   cnt_q;
  logic            push, pop;

  assign wr_ready_o = cnt_q != (PtrW+1)'(FifoDepth);
  assign rd_valid_o = cnt_q != '0;
  assign push       = wr_valid_i && wr_ready_o;
  assign pop        = rd_valid_o && rd_ready_i;
  assign rd_data_o  = mem_q[rp_q];

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push) wp_q <= wp_q + PtrW'(1);
      if (pop)  rp_q <= rp_q + PtrW'(1);
      if (push && !pop)      cnt_q <= cnt_q + (PtrW+1)'(1);
      else if (pop && !push) cnt_q <= cnt_q - (PtrW+1)'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wp_q] <= wr_data_i;
    end
  end

endmodule

@@ sv/bmc_back.sv @@
// Back end: areas, products and a pipelined restoring divider giving the cost.
// Depends on bmc_pkg.
module bmc_back (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   geom_valid_i,
  output logic                   geom_ready_o,
  input  bmc_pkg::bmc_geom_t     geom_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic [bmc_pkg::QW-1:0] cost_o
);
  import bmc_pkg::*;

  logic en, take;
  logic [5:1] v_q;

  // stage 1: products of spans
  logic [AreaW-1:0] inter1_q, areaa1_q, areab1_q;
  logic [DxyW-1:0]  dxy1_q, dxy2_q;
  logic [AwhW-1:0]  awh1_q, awh2_q;
  // stage 2: union and union minus intersection
  logic [UniW-1:0]  uni2_q, ui2_q, ui3_q;
  // stage 3 and 4: dividend and divisor
  logic [Num1W-1:0] num3_q;
  logic [DenW-1:0]  den3_q;
  logic [NumW-1:0]  num4_q;
  logic [DenW-1:0]  den4_q;
  // divider stages, index 0 is the entry
  logic [NumW-1:0]  rem_q  [QW+1];
  logic [DenW-1:0]  dden_q [QW+1];
  logic [QW-1:0]    quo_q  [QW+1];
  logic             zero_q [QW+1];
  logic             sat_q  [QW+1];
  // dv_q[s-1] marks divider stage s as valid
  logic [QW-1:0]    dv_q;
  logic [QW-1:0]    cost_q;
  logic             out_v_q;

  assign en           = !out_v_q || out_ready_i;
  assign take         = en && geom_valid_i;
  assign geom_ready_o = en;

  // valid bits along the pipe
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q     <= '0;
      dv_q    <= '0;
      out_v_q <= 1'b0;
    end else if (en) begin
      v_q     <= {v_q[4:1], take};
      dv_q    <= {dv_q[QW-2:0], v_q[5]};
      out_v_q <= dv_q[QW-1];
    end
  end

  // arithmetic front of the pipe
  always_ff @(posedge clk_i) begin
    if (en) begin
      inter1_q <= AreaW'(geom_i.wx * geom_i.hx);
      areaa1_q <= AreaW'(geom_i.aw1 * geom_i.ah1);
      areab1_q <= AreaW'(geom_i.bw1 * geom_i.bh1);
      dxy1_q   <= geom_i.dx * geom_i.dy;
      awh1_q   <= geom_i.aw * geom_i.ah;

      uni2_q <= UniW'(areaa1_q) + UniW'(areab1_q) - UniW'(inter1_q);
      ui2_q  <= UniW'(areaa1_q) + UniW'(areab1_q) - UniW'({inter1_q, 1'b0});
      dxy2_q <= dxy1_q;
      awh2_q <= awh1_q;

      num3_q <= Num1W'(dxy2_q) * Num1W'(100);
      den3_q <= DenW'(uni2_q) * DenW'(awh2_q);
      ui3_q  <= ui2_q;

      num4_q <= NumW'(num3_q) * NumW'(ui3_q);
      den4_q <= den3_q;

      // entry: zero dividend gives one, quotient overflow saturates
      rem_q[0]  <= num4_q;
      dden_q[0] <= den4_q;
      quo_q[0]  <= '0;
      zero_q[0] <= num4_q == '0;
      sat_q[0]  <= (num4_q != '0) && (ShW'(num4_q) >= (ShW'(den4_q) << QW));
    end
  end

  // one quotient bit per stage, most significant first
  for (genvar s = 1; s <= QW; s++) begin : g_div
    logic [ShW-1:0] dsh;
    logic           ge;
    assign dsh = ShW'(dden_q[s-1]) << (QW - s);
    assign ge  = ShW'(rem_q[s-1]) >= dsh;
    always_ff @(posedge clk_i) begin
      if (en) begin
        rem_q[s]  <= ge ? NumW'(ShW'(rem_q[s-1]) - dsh) : rem_q[s-1];
        quo_q[s]  <= quo_q[s-1] | (ge ? (QW'(1) << (QW - s)) : '0);
        dden_q[s] <= dden_q[s-1];
        zero_q[s] <= zero_q[s-1];
        sat_q[s]  <= sat_q[s-1];
      end
    end
  end

  // output register with floor at one and saturation
  always_ff @(posedge clk_i) begin
    if (en) begin
      if (zero_q[QW] || (quo_q[QW] == '0 && !sat_q[QW])) cost_q <= CostOne;
      else if (sat_q[QW])                                cost_q <= CostMax;
      else                                               cost_q <= quo_q[QW];
    end
  end

  assign out_valid_o = out_v_q;
  assign cost_o      = cost_q;

endmodule

@@ sv/box_match_cost_top.sv @@
// Box matching cost: IoU weighted center distance cost of a box pair.
// Throughput one pair per cycle when the output is not stalled; the restoring divider is fully pipelined in 31 stages.
// A 4-entry queue parts front and back; output stalls back up through it.
// Asynchronous active-low reset clears valid bits, queue pointers and fill count only.
// Depends on bmc_pkg, bmc_front, bmc_fifo, bmc_back.
module box_match_cost_top #(
  parameter int COORD_MAX = bmc_pkg::CoordMaxDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_tvalid,
  output logic        s_tready,
  // first_x, first_y, first_width, first_height,
  // second_x, second_y, second_width, second_height (12 bits each)
  input  logic [95:0] s_tdata,
  output logic        m_tvalid,
  input  logic        m_tready,
  // cost [30:0], bit 31 zero
  output logic [31:0] m_tdata
);
  import bmc_pkg::*;

  bmc_geom_t     f_geom, q_geom;
  logic          f_valid, f_ready, q_valid, q_ready;
  logic [QW-1:0] cost;

  bmc_front #(.COORD_MAX(COORD_MAX)) u_front (
    .clk_i, .rst_ni,
    .in_valid_i(s_tvalid), .in_ready_o(s_tready), .in_data_i(s_tdata),
    .geom_valid_o(f_valid), .geom_ready_i(f_ready), .geom_o(f_geom)
  );

  bmc_fifo u_fifo (
    .clk_i, .rst_ni,
    .wr_valid_i(f_valid), .wr_ready_o(f_ready), .wr_data_i(f_geom),
    .rd_valid_o(q_valid), .rd_ready_i(q_ready), .rd_data_o(q_geom)
  );

  bmc_back u_back (
    .clk_i, .rst_ni,
    .geom_valid_i(q_valid), .geom_ready_o(q_ready), .geom_i(q_geom),
    .out_valid_o(m_tvalid), .out_ready_i(m_tready), .cost_o(cost)
  );

  assign m_tdata = {1'b0, cost};

endmodule

@@ tb/tb_box_match_cost_top.sv @@
// Testbench for box_match_cost_top: streams box pairs and checks each cost
// against an in-bench predictor of the IoU weighted center distance cost.
// Depends on box_match_cost_top.
module tb_box_match_cost_top;

  localparam int CoordMax  = 4095;
  localparam int IdleLimit = 5000;
  localparam int RandItems = 800;

  // Pending costs, in order of accepted pairs
  class cost_scoreboard;
    logic [30:0] pending_q[$];
    int          errors;

    function new();
      errors = 0;
    endfunction

    function logic [11:0] clamp(logic [11:0] v);
      return (v > CoordMax) ? 12'(CoordMax) : v;
    endfunction

    // Predict the cost of one pair and queue it
    function void note_pair(logic [95:0] pair);
      logic [63:0] ax, ay, aw, ah, bx, by, bw, bh;
      logic [63:0] xa, ya, xb, yb, inter, uni, dx, dy, ca, cb, num, den, cost;
      ax = 64'(clamp(pair[11:0]));   ay = 64'(clamp(pair[23:12]));
      aw = 64'(clamp(pair[35:24]));  ah = 64'(clamp(pair[47:36]));
      bx = 64'(clamp(pair[59:48]));  by = 64'(clamp(pair[71:60]));
      bw = 64'(clamp(pair[83:72]));  bh = 64'(clamp(pair[95:84]));
      xa = (ax > bx) ? ax : bx;
      ya = (ay > by) ? ay : by;
      xb = (ax + aw < bx + bw) ? ax + aw : bx + bw;
      yb = (ay + ah < by + bh) ? ay + ah : by + bh;
      inter = (xb > xa && yb > ya) ? (xb - xa + 1) * (yb - ya + 1) : 0;
      uni = (aw + 1) * (ah + 1) + (bw + 1) * (bh + 1) - inter;
      ca = ax + aw / 2; cb = bx + bw / 2;
      dx = (ca > cb) ? ca - cb : cb - ca;
      ca = ay + ah / 2; cb = by + bh / 2;
      dy = (ca > cb) ? ca - cb : cb - ca;
      num = 64'd100 * dx * dy * (uni - inter);
      den = uni * aw * ah;
      if (den == 0) cost = (num == 0) ? 0 : 64'h7FFF_FFFF;
      else cost = num / den;
      if (cost == 0) cost = 1;
      if (cost > 64'h7FFF_FFFF) cost = 64'h7FFF_FFFF;
      pending_q.insert(pending_q.size(), cost[30:0]);
    endfunction

    function void check_cost(logic [31:0] word);
      logic [30:0] exp_cost;
      if (pending_q.size() == 0) begin
        $display("%0t: unexpected cost %0d", $time, word[30:0]);
        errors++;
        return;
      end
      exp_cost = pending_q.pop_front();
      if (word[30:0] !== exp_cost || word[31] !== 1'b0) begin
        $display("%0t: cost mismatch expected %0d actual %0d (bit31 %b)",
                 $time, exp_cost, word[30:0], word[31]);
        errors++;
      end
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [95:0] s_tdata = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [31:0] m_tdata;

  cost_scoreboard sb = new();
  int  idle_cycles = 0;

  box_match_cost_top uut (
    .clk_i, .rst_ni, .s_tvalid, .s_tready, .s_tdata,
    .m_tvalid, .m_tready, .m_tdata
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Receiver: stall pattern of its own, with stall-free stretches
  initial begin
    int phase;
    phase = 0;
    forever begin
      @(posedge clk_i);
      phase++;
      if ((phase / 200) % 3 == 0) m_tready <= 1'b1;
      else m_tready <= ($urandom_range(0, 3) != 0);
    end
  end

  // Check results and watch for a stuck block
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_tvalid && m_tready) sb.check_cost(m_tdata);
      if ((m_tvalid && m_tready) || (s_tvalid && s_tready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IdleLimit) begin
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  function automatic logic [11:0] rand_field(int mode);
    case (mode)
      0: return 12'd0;
      1: return 12'hFFF;
      default: return 12'($urandom);
    endcase
  endfunction

  // Drive one pair; hold until transferred
  task automatic send_pair(logic [95:0] pair);
    s_tvalid <= 1'b1;
    s_tdata  <= pair;
    @(posedge clk_i);
    while (!s_tready) @(posedge clk_i);
    sb.note_pair(pair);
  endtask

  // Idle gap; a zero-length gap leaves the stream untouched
  task automatic send_gap(int n);
    if (n > 0) begin
      s_tvalid <= 1'b0;
      repeat (n) @(posedge clk_i);
    end
  endtask

  // Random pair: mostly overlapping boxes of modest size, sometimes anything
  function automatic logic [95:0] random_pair();
    logic [11:0] f[8];
    int kind;
    kind = $urandom_range(0, 9);
    if (kind < 6) begin
      f[0] = 12'($urandom_range(0, 3000)); f[1] = 12'($urandom_range(0, 3000));
      f[2] = 12'($urandom_range(1, 400));  f[3] = 12'($urandom_range(1, 400));
      f[4] = f[0] + 12'($urandom_range(0, 300)) - 12'd150;
      f[5] = f[1] + 12'($urandom_range(0, 300)) - 12'd150;
      f[6] = 12'($urandom_range(0, 400));  f[7] = 12'($urandom_range(0, 400));
    end else begin
      foreach (f[i]) f[i] = rand_field($urandom_range(0, 12));
    end
    return {f[7], f[6], f[5], f[4], f[3], f[2], f[1], f[0]};
  endfunction

  initial begin
    logic [95:0] pair;
    int burst;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: identical boxes, all zeros, all extremes, zero sizes, disjoint
    send_pair({12'd10, 12'd10, 12'd5, 12'd5, 12'd10, 12'd10, 12'd5, 12'd5});
    send_pair('0);
    send_pair({96{1'b1}});
    send_pair({12'd0, 12'd0, 12'd100, 12'd100, 12'd0, 12'd0, 12'd0, 12'd0});
    send_pair({12'd0, 12'd0, 12'd4095, 12'd4095, 12'd0, 12'd0, 12'd0, 12'd0});
    send_pair({12'hFFF, 12'hFFF, 12'd0, 12'd0, 12'd1, 12'd1, 12'd0, 12'd0});
    send_pair({12'd1, 12'd1, 12'd4095, 12'd4095, 12'd1, 12'd1, 12'd0, 12'd0});
    send_pair({12'd1, 12'd1, 12'd0, 12'd0, 12'd1, 12'd1, 12'd1, 12'd1});
    send_pair({12'd3, 12'd3, 12'd50, 12'd60, 12'd3, 12'd2, 12'd50, 12'd60});
    send_pair({12'd20, 12'd20, 12'd10, 12'd10, 12'd10, 12'd10, 12'd20, 12'd20});
    send_pair({12'd0, 12'd4095, 12'd0, 12'd4095, 12'd0, 12'd4095, 12'd0, 12'd4095});
    send_pair({12'hAAA, 12'h555, 12'hAAA, 12'h555, 12'h555, 12'hAAA, 12'h555, 12'hAAA});
    send_pair({12'd5, 12'd5, 12'd10, 12'd10, 12'd3, 12'd3, 12'd10, 12'd10});

    // Random bursts with random gaps
    for (int sent = 0; sent < RandItems; ) begin
      burst = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 8);
      for (int k = 0; k < burst && sent < RandItems; k++, sent++) begin
        pair = random_pair();
        send_pair(pair);
      end
      send_gap($urandom_range(0, 6));
    end
    s_tvalid <= 1'b0;

    while (sb.pending_q.size() != 0) @(posedge clk_i);
    repeat (60) @(posedge clk_i);
    if (sb.errors == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end

endmodule

@@ filelist.f @@
sv/bmc_pkg.sv
sv/bmc_front.sv
sv/bmc_fifo.sv
sv/bmc_back.sv
sv/box_match_cost_top.sv
tb/tb_box_match_cost_top.sv
